>>> rtl/core/crsf_pkg.sv
// Package for the serial RC frame receiver: frame geometry, CRC helper,
// configuration and pipeline types. No dependencies.
`timescale 1ns / 1ps

package crsf_pkg;

   localparam int PAYLOAD_BYTES   = 22;
   localparam int NUM_CHANNELS    = 5;
   localparam int CHANNEL_BITS    = 11;

   localparam int FRAME_BYTES     = PAYLOAD_BYTES + 4;
   localparam int MAX_LENGTH      = PAYLOAD_BYTES + 2;
   localparam int POS_W           = $clog2(FRAME_BYTES);
   localparam int CHAN_FIELD_BITS = NUM_CHANNELS * CHANNEL_BITS;
   localparam int CHAN_BYTES      = (CHAN_FIELD_BITS + 7) / 8;
   localparam int CHAN_IDX_W      = $clog2(CHAN_BYTES);
   localparam int SCALE_W         = 16;
   localparam int OFFSET_W        = 12;
   localparam int OUT_W           = 13;

   localparam logic [POS_W-1:0] POS_SYNC   = POS_W'(0);
   localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(1);
   localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(2);
   localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

   localparam logic [7:0] CRC_POLY = 8'hD5;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SYNC_VALUE    = 2'd0;
   localparam logic [1:0] CSR_RC_FRAME_TYPE = 2'd1;
   localparam logic [1:0] CSR_SCALE_Q16     = 2'd2;
   localparam logic [1:0] CSR_OFFSET_US     = 2'd3;

   typedef struct packed {
      logic [7:0]          sync_value;
      logic [7:0]          rc_frame_type;
      logic [SCALE_W-1:0]  scale_q16;
      logic [OFFSET_W-1:0] offset_us;
   } cfg_type;

   typedef logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] raw_chan_type;

   // A frame that passed the length and CRC checks.
   typedef struct packed {
      logic         vld;
      logic [7:0]   kind;
      logic         rc;
      raw_chan_type raw;
   } frame_evt_type;

   // One byte of CRC-8, MSB first, no final xor.
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/core/crsf_csr.sv
// Configuration registers of the RC frame receiver.
// Depends on crsf_pkg for the register indexes and the cfg_type struct.
`timescale 1ns / 1ps

module crsf_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data,
   output crsf_pkg::cfg_type cfg
);
   import crsf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_VALUE:    cfg_in.sync_value    = csr_data[7:0];
            CSR_RC_FRAME_TYPE: cfg_in.rc_frame_type = csr_data[7:0];
            CSR_SCALE_Q16:     cfg_in.scale_q16     = csr_data[SCALE_W-1:0];
            CSR_OFFSET_US:     cfg_in.offset_us     = csr_data[OFFSET_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value    <= 8'd200;
         cfg_ff.rc_frame_type <= 8'd22;
         cfg_ff.scale_q16     <= 16'd40945;
         cfg_ff.offset_us     <= 12'd881;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/crsf_parser.sv
// Byte sequencer of the RC frame receiver: sync hunt, length, running CRC,
// channel field capture, and the checked frame event. Depends on crsf_pkg.
`timescale 1ns / 1ps

module crsf_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  crsf_pkg::cfg_type       cfg,
   input  logic                    byte_accept,
   input  logic [7:0]              rx_data,
   output logic                    at_last,
   output crsf_pkg::frame_evt_type evt
);
   import crsf_pkg::*;

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [7:0]              len_ff, len_in;
   logic [7:0]              kind_ff, kind_in;
   logic [7:0]              crc_ff, crc_in;
   logic [7:0]              crc_len_ff, crc_len_in;
   logic [CHAN_BYTES*8-1:0] chan_ff, chan_in;
   frame_evt_type           evt_ff, evt_in;
   logic [7:0]              crc_next;
   logic [POS_W-1:0]        chan_pos;
   logic                    len_ok;

   assign at_last  = (pos_ff == POS_LAST);
   assign evt      = evt_ff;
   assign crc_next = crc8_feed(crc_ff, rx_data);
   assign chan_pos = pos_ff - POS_FIRST;
   assign len_ok   = (len_ff >= 8'd1) && (len_ff <= 8'(MAX_LENGTH));

   always_comb begin
      pos_in     = pos_ff;
      len_in     = len_ff;
      kind_in    = kind_ff;
      crc_in     = crc_ff;
      crc_len_in = crc_len_ff;
      chan_in    = chan_ff;
      evt_in     = evt_ff;
      evt_in.vld = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         evt_in.raw[i] = chan_ff[i*CHANNEL_BITS +: CHANNEL_BITS];
      end
      evt_in.kind = kind_ff;
      evt_in.rc   = (kind_ff == cfg.rc_frame_type);
      if (byte_accept) begin
         if (pos_ff == POS_SYNC) begin
            if (rx_data == cfg.sync_value) begin
               pos_in = POS_LENGTH;
            end
         end else if (pos_ff == POS_LENGTH) begin
            len_in     = rx_data;
            crc_in     = 8'd0;
            crc_len_in = 8'd0;
            pos_in     = POS_TYPE;
         end else if (!at_last) begin
            crc_in = crc_next;
            // The CRC covers length-1 bytes; keep it once that many are in.
            if ({{(8-POS_W){1'b0}}, pos_ff} == len_ff) begin
               crc_len_in = crc_next;
            end
            if (pos_ff == POS_TYPE) begin
               kind_in = rx_data;
            end else if (chan_pos < POS_W'(CHAN_BYTES)) begin
               chan_in[chan_pos[CHAN_IDX_W-1:0]*8 +: 8] = rx_data;
            end
            pos_in = pos_ff + POS_W'(1);
         end else begin
            pos_in     = POS_SYNC;
            evt_in.vld = len_ok && (crc_len_ff == rx_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_SYNC;
         len_ff     <= 8'd0;
         kind_ff    <= 8'd0;
         crc_ff     <= 8'd0;
         crc_len_ff <= 8'd0;
         evt_ff.vld <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         kind_ff    <= kind_in;
         crc_ff     <= crc_in;
         crc_len_ff <= crc_len_in;
         evt_ff.vld <= evt_in.vld;
      end
      chan_ff     <= chan_in;
      evt_ff.kind <= evt_in.kind;
      evt_ff.rc   <= evt_in.rc;
      evt_ff.raw  <= evt_in.raw;
   end

endmodule

>>> rtl/core/crsf_scaler.sv
// Channel scaling and result register of the RC frame receiver: one
// multiplier per channel, then offset add, held channels and output word.
// Depends on crsf_pkg.
`timescale 1ns / 1ps

module crsf_scaler (
   input  logic                    clock,
   input  logic                    reset,
   input  crsf_pkg::cfg_type       cfg,
   input  crsf_pkg::frame_evt_type evt,
   output logic                    busy,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_frame_type,
   output logic                    rsp_rc_updated,
   output logic [crsf_pkg::NUM_CHANNELS-1:0][crsf_pkg::OUT_W-1:0] held
);
   import crsf_pkg::*;

   localparam int PROD_W = CHANNEL_BITS + SCALE_W;

   logic                                       prod_vld_ff;
   logic [7:0]                                 prod_kind_ff;
   logic                                       prod_rc_ff;
   logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0]  prod_ff, prod_in;
   logic [NUM_CHANNELS-1:0][OUT_W-1:0]         held_ff, held_in;
   logic                                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                                 type_ff;
   logic                                       rc_ff;
   logic [PROD_W-1:0]                          full_prod [NUM_CHANNELS];

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         full_prod[i] = PROD_W'(evt.raw[i]) * PROD_W'(cfg.scale_q16);
         prod_in[i]   = full_prod[i][PROD_W-1:SCALE_W];
      end
   end

   // The sum stays below 2^13, so no saturation is needed at these widths.
   always_comb begin
      held_in = held_ff;
      if (prod_vld_ff && prod_rc_ff) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            held_in[i] = OUT_W'(prod_ff[i]) + OUT_W'(cfg.offset_us);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (prod_vld_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         prod_vld_ff  <= evt.vld;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
      end
      prod_ff      <= prod_in;
      prod_kind_ff <= evt.kind;
      prod_rc_ff   <= evt.rc;
      if (prod_vld_ff) begin
         type_ff <= prod_kind_ff;
         rc_ff   <= prod_rc_ff;
      end
   end

   assign busy           = evt.vld || prod_vld_ff || rsp_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_type = type_ff;
   assign rsp_rc_updated = rc_ff;
   assign held           = held_ff;

endmodule

>>> rtl/core/crsf_rc_frame_receiver.sv
// Top level of the serial RC frame receiver with CRC-8 check.
// Instantiates crsf_csr, crsf_parser and crsf_scaler; depends on crsf_pkg.
`timescale 1ns / 1ps

// Usage:
// The req_ channel carries one received serial byte per word. Bytes are
// dropped until one matches sync_value; then a fixed 26-byte frame is
// collected (sync, length, type, 22 payload bytes, CRC). A byte is taken
// every cycle while req_stall is low, the CRC being updated as each byte
// arrives. When the last byte of a frame has a good length and CRC, one
// word appears on the rsp_ channel once it has passed the frame event,
// product and output registers: the frame type, an RC flag and the five
// held channels. An RC frame refreshes the channels as
// ((raw * scale_q16) >> 16) + offset_us.
// The rsp_ word stays in its output register until taken. Bytes keep being
// accepted while it waits; only the last byte of the next frame is stalled
// while an earlier result is still in the pipeline or unclaimed.
// The csr_ channel writes the four registers and is always ready; write
// them only while no frame is in progress. Synchronous reset restores the
// register defaults, restarts the sync hunt and clears the held channels.
module crsf_rc_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_type,
   output logic        rsp_rc_updated,
   output logic [12:0] rsp_channel_1,
   output logic [12:0] rsp_channel_2,
   output logic [12:0] rsp_channel_3,
   output logic [12:0] rsp_channel_4,
   output logic [12:0] rsp_channel_5,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import crsf_pkg::*;

   cfg_type                            cfg;
   frame_evt_type                      evt;
   logic                               at_last;
   logic                               busy;
   logic                               byte_accept;
   logic [NUM_CHANNELS-1:0][OUT_W-1:0] held;

   assign req_stall   = at_last && busy;
   assign byte_accept = req_valid && !req_stall;

   crsf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   crsf_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .byte_accept (byte_accept),
      .rx_data     (req_rx_data),
      .at_last     (at_last),
      .evt         (evt)
   );

   crsf_scaler u_scaler (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .evt            (evt),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_type (rsp_frame_type),
      .rsp_rc_updated (rsp_rc_updated),
      .held           (held)
   );

   assign rsp_channel_1 = held[0];
   assign rsp_channel_2 = held[1];
   assign rsp_channel_3 = held[2];
   assign rsp_channel_4 = held[3];
   assign rsp_channel_5 = held[4];

endmodule

>>> tb/sv/crsf_rc_frame_receiver_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for crsf_rc_frame_receiver: serial bytes are driven, every
// completed frame word is predicted and checked field by field.
// Depends on crsf_pkg and the receiver RTL.

module crsf_rc_frame_receiver_test;
   import crsf_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_BYTES  = 180;
   localparam int DRAIN_CYCLES = 12;
   localparam int BUSY_PCT     = 28;

   typedef struct packed {
      logic [7:0]                         frame_type;
      logic                               rc_updated;
      logic [NUM_CHANNELS-1:0][OUT_W-1:0] channels;
   } frame_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_data = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_type;
   logic        rsp_rc_updated;
   logic [12:0] rsp_channel_1;
   logic [12:0] rsp_channel_2;
   logic [12:0] rsp_channel_3;
   logic [12:0] rsp_channel_4;
   logic [12:0] rsp_channel_5;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SYNC_VALUE;
   logic [15:0] csr_data = 16'h0000;

   int          req_idle_pct = BUSY_PCT;
   int          rsp_idle_pct = BUSY_PCT;
   int unsigned cycle_count = 0;

   // CRC-8, polynomial 0xD5, MSB first.
   function automatic logic [7:0] crc_dvb(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
      return r;
   endfunction

   class rc_frame_tracker;
      cfg_type          cfg;
      int unsigned      byte_pos;
      logic [7:0]       frame_len;
      logic [7:0]       frame_kind;
      logic [7:0]       crc_run;
      logic [7:0]       crc_at_len;
      logic [7:0]       payload [PAYLOAD_BYTES];
      logic [OUT_W-1:0] held [NUM_CHANNELS];
      frame_word_type   pending_words [$];
      int               errors;

      function new();
         cfg.sync_value    = 8'd200;
         cfg.rc_frame_type = 8'd22;
         cfg.scale_q16     = 16'd40945;
         cfg.offset_us     = 12'd881;
         byte_pos   = 0;
         frame_len  = 8'h00;
         frame_kind = 8'h00;
         crc_run    = 8'h00;
         crc_at_len = 8'h00;
         foreach (payload[i]) payload[i] = 8'h00;
         foreach (held[i]) held[i] = '0;
         errors = 0;
      endfunction

      function void set_register(input logic [1:0] idx, input logic [15:0] value);
         case (idx)
            CSR_SYNC_VALUE:    cfg.sync_value    = value[7:0];
            CSR_RC_FRAME_TYPE: cfg.rc_frame_type = value[7:0];
            CSR_SCALE_Q16:     cfg.scale_q16     = value;
            CSR_OFFSET_US:     cfg.offset_us     = value[OFFSET_W-1:0];
            default: ;
         endcase
      endfunction

      // Advances the frame state by one accepted byte and queues the word it completes.
      function void take_byte(input logic [7:0] b);
         frame_word_type word;
         logic [31:0] raw;
         logic [47:0] scaled;
         int          ch;
         int          k;
         int          bit_at;
         if (byte_pos == 0) begin
            if (b == cfg.sync_value) byte_pos = 1;
            return;
         end
         if (byte_pos == 1) begin
            frame_len  = b;
            crc_run    = 8'h00;
            crc_at_len = 8'h00;
            byte_pos   = 2;
            return;
         end
         if (byte_pos < FRAME_BYTES - 1) begin
            crc_run = crc_dvb(crc_run, b);
            if (byte_pos == frame_len) crc_at_len = crc_run;
            if (byte_pos == 2) frame_kind = b;
            else payload[byte_pos - 3] = b;
            byte_pos++;
            return;
         end
         // Last byte of the frame carries the received CRC.
         byte_pos = 0;
         if (frame_len < 1 || frame_len > MAX_LENGTH || crc_at_len != b) return;
         word.rc_updated = (frame_kind == cfg.rc_frame_type);
         if (word.rc_updated) begin
            for (ch = 0; ch < NUM_CHANNELS; ch++) begin
               raw = '0;
               for (k = 0; k < CHANNEL_BITS; k++) begin
                  bit_at = ch * CHANNEL_BITS + k;
                  if (bit_at / 8 < PAYLOAD_BYTES) raw[k] = payload[bit_at / 8][bit_at % 8];
               end
               scaled = ((raw * cfg.scale_q16) >> 16) + cfg.offset_us;
               held[ch] = (scaled > 48'd8191) ? 13'h1FFF : scaled[OUT_W-1:0];
            end
         end
         word.frame_type = frame_kind;
         for (ch = 0; ch < NUM_CHANNELS; ch++) word.channels[ch] = held[ch];
         pending_words.push_back(word);
      endfunction

      function void mismatch(input string what, input int unsigned want, input int unsigned got);
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      endfunction

      function void check_word(input frame_word_type got);
         frame_word_type want;
         int          ch;
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected frame word, type %0d", $time, got.frame_type);
            return;
         end
         want = pending_words.pop_front();
         if (got.frame_type !== want.frame_type)
            mismatch("frame_type", want.frame_type, got.frame_type);
         if (got.rc_updated !== want.rc_updated)
            mismatch("rc_updated", want.rc_updated, got.rc_updated);
         for (ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (got.channels[ch] !== want.channels[ch])
               mismatch($sformatf("channel_%0d", ch + 1), want.channels[ch], got.channels[ch]);
         end
      endfunction
   endclass

   rc_frame_tracker tracker;

   crsf_rc_frame_receiver u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_data    (req_rx_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_type (rsp_frame_type),
      .rsp_rc_updated (rsp_rc_updated),
      .rsp_channel_1  (rsp_channel_1),
      .rsp_channel_2  (rsp_channel_2),
      .rsp_channel_3  (rsp_channel_3),
      .rsp_channel_4  (rsp_channel_4),
      .rsp_channel_5  (rsp_channel_5),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   always @(posedge clock) begin : word_monitor
      frame_word_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.frame_type  = rsp_frame_type;
         seen.rc_updated  = rsp_rc_updated;
         seen.channels[0] = rsp_channel_1;
         seen.channels[1] = rsp_channel_2;
         seen.channels[2] = rsp_channel_3;
         seen.channels[3] = rsp_channel_4;
         seen.channels[4] = rsp_channel_5;
         tracker.check_word(seen);
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_data <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_byte(b);
      @(negedge clock);
   endtask

   task automatic configure(input logic [7:0] sync, input logic [7:0] kind,
                            input logic [15:0] scale, input logic [11:0] offset);
      logic [1:0]  regs [4];
      logic [15:0] values [4];
      regs[0] = CSR_SYNC_VALUE;    values[0] = {8'h00, sync};
      regs[1] = CSR_RC_FRAME_TYPE; values[1] = {8'h00, kind};
      regs[2] = CSR_SCALE_Q16;     values[2] = scale;
      regs[3] = CSR_OFFSET_US;     values[3] = {4'h0, offset};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= values[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         tracker.set_register(regs[i], values[i]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Lengths below 2 or above MAX_LENGTH get a zero CRC byte, which is what the CRC capture holds
   // for them, so with good_crc set only the length check can reject them.
   task automatic send_frame(input logic [7:0] len, input logic [7:0] kind, input bit good_crc,
                             input logic [7:0] body [PAYLOAD_BYTES]);
      logic [7:0] crc;
      crc = 8'h00;
      if (len >= 2 && len <= MAX_LENGTH) begin
         crc = crc_dvb(8'h00, kind);
         for (int i = 0; i < len - 2; i++) crc = crc_dvb(crc, body[i]);
      end
      if (!good_crc) crc ^= 8'(1 << $urandom_range(0, 7));
      send_byte(tracker.cfg.sync_value);
      send_byte(len);
      send_byte(kind);
      foreach (body[i]) send_byte(body[i]);
      send_byte(crc);
   endtask

   task automatic send_random_frame();
      logic [7:0] body [PAYLOAD_BYTES];
      logic [7:0] len;
      logic [7:0] kind;
      int         pick;
      if ($urandom_range(0, 99) < 25) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      kind = ($urandom_range(0, 99) < 60) ? tracker.cfg.rc_frame_type : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) len = 8'(MAX_LENGTH);
      else if (pick < 85) len = 8'($urandom_range(1, MAX_LENGTH));
      else if (pick < 90) len = 8'h00;
      else len = 8'($urandom_range(MAX_LENGTH + 1, 255));
      pick = $urandom_range(0, 99);
      foreach (body[i]) begin
         if (pick < 10) body[i] = 8'h00;
         else if (pick < 20) body[i] = 8'hFF;
         else body[i] = 8'($urandom);
      end
      if ($urandom_range(0, 99) < 20)
         body[$urandom_range(0, PAYLOAD_BYTES - 1)] = tracker.cfg.sync_value;
      send_frame(len, kind, $urandom_range(0, 99) < 85, body);
   endtask

   // Completes any partial frame, then waits until every word has been taken.
   task automatic settle();
      while (tracker.byte_pos != 0) send_byte(8'($urandom));
      req_valid <= 1'b0;
      while (tracker.pending_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [7:0] body [PAYLOAD_BYTES];
      int         sent;
      tracker = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames under the reset register values.
      send_byte(8'h00);
      send_byte(8'hFF);
      foreach (body[i]) body[i] = 8'h00;
      send_frame(8'd24, 8'd22, 1'b1, body);
      foreach (body[i]) body[i] = 8'hFF;
      send_frame(8'd24, 8'd22, 1'b1, body);
      send_frame(8'd24, 8'hFF, 1'b1, body);
      // Sync bytes inside a frame are plain frame bytes.
      foreach (body[i]) body[i] = 8'd200;
      send_frame(8'd24, 8'd22, 1'b1, body);
      foreach (body[i]) body[i] = 8'($urandom);
      send_frame(8'd24, 8'h29, 1'b1, body);
      send_frame(8'd24, 8'd22, 1'b0, body);
      send_frame(8'd1, 8'd22, 1'b1, body);
      send_frame(8'd0, 8'd22, 1'b1, body);
      send_frame(8'd25, 8'd22, 1'b1, body);
      send_frame(8'd255, 8'h00, 1'b1, body);
      send_frame(8'd2, 8'h00, 1'b1, body);
      settle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: configure(8'h00, 8'h00, 16'h0000, 12'h000);
            1: configure(8'hFF, 8'hFF, 16'hFFFF, 12'hFFF);
            5: configure(8'd200, 8'd22, 16'd40945, 12'd881);
            default: configure(8'($urandom), 8'($urandom), 16'($urandom), 12'($urandom));
         endcase
         // One phase runs without any idling on either side.
         req_idle_pct = (p == 2) ? 0 : BUSY_PCT;
         rsp_idle_pct = (p == 2) ? 0 : BUSY_PCT;
         sent = 0;
         while (sent < PHASE_BYTES) begin
            send_random_frame();
            sent += FRAME_BYTES;
         end
         settle();
      end

      if (tracker.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
